// File: hw/rtl/gbn_pkg.sv
// ---------------------------------------------------------------------------
// gbn_pkg: shared types and constants for the go-back-N ARQ endpoint
// Sequence arithmetic, item kinds, sequencer states and stream layouts.
// ---------------------------------------------------------------------------
package gbn_pkg;

    // Sequence space
    localparam int SEQ_W   = 3;
    localparam int SEQ_MOD = 8;
    localparam int MAX_SEQ = 7;
    localparam logic [SEQ_W-1:0] MAX_SEQ_V = SEQ_W'(MAX_SEQ);
    localparam logic [SEQ_W-1:0] SEQ_LAST  = SEQ_W'(SEQ_MOD - 1);

    // Word widths
    localparam int WORD_W = 32;
    localparam logic [WORD_W-1:0] MAX_WAIT_RST = WORD_W'(10);

    // Input stream layout
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 3;

    // Result stream layout
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;
    localparam int M_ARM_BIT = 70;
    localparam int M_TXF_HI  = 37;  // top bit of tx_seq, tx_ack, tx_payload

    // Item kinds carried in s_tuser[1:0]
    typedef enum logic [1:0] {
        KIND_SEND    = 2'd0,
        KIND_TIMEOUT = 2'd1,
        KIND_RX      = 2'd2
    } kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND,
        ST_ACK,
        ST_TO_RD,
        ST_TO_LD,
        ST_FIN,
        ST_OUT
    } state_t;

    // Advance a sequence number with wrap
    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] x);
        logic [SEQ_W-1:0] r;
        if (x == SEQ_LAST) begin
            r = '0;
        end else begin
            r = x + SEQ_W'(1);
        end
        return r;
    endfunction

    // True when b lies in the circular window [a, c)
    function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b,
                                       input logic [SEQ_W-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

endpackage

// File: hw/rtl/go_back_n_arq_endpoint_core.sv
// Sequence: a send request passes ST_SEND, ST_FIN and ST_OUT; a received frame
//   passes ST_ACK, retiring acknowledged frames there, then ST_FIN and ST_OUT.
// A new item is taken only in ST_IDLE, after the last result is taken; a timeout
//   event passes ST_TO_RD, ST_TO_LD and ST_OUT for each resent frame.
// Reset (aresetn low, synchronous): sequence state, send-time valid bits and
//   handshakes clear, max_wait returns to 10.
// ---------------------------------------------------------------------------
// go_back_n_arq_endpoint_core: go-back-N ARQ endpoint
// Sequencer over a frame store and send-time table; one shared age compare.
// ---------------------------------------------------------------------------
module go_back_n_arq_endpoint_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: max_wait
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gbn_pkg::WORD_W-1:0]     cfg_data,
    // Input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now[31:0], send_payload[63:32], rx_seq[66:64], rx_ack[69:67],
    // rx_payload[101:70], zero[103:102]
    input  logic [gbn_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind[1:0], rx_has_data[2]
    input  logic [gbn_pkg::S_TUSER_W-1:0]  s_tuser,
    // Results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tx_seq[2:0], tx_ack[5:3], tx_payload[37:6], deliver_payload[69:38],
    // arm_timeout[70], zero[71]
    output logic [gbn_pkg::M_TDATA_W-1:0]  m_tdata,
    // tx_valid[0], deliver_valid[1]
    output logic [gbn_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tlast
);

    localparam int SW = gbn_pkg::SEQ_W;
    localparam int WW = gbn_pkg::WORD_W;

    gbn_pkg::state_t state_reg, state_next;

    logic [WW-1:0] max_wait_reg;
    logic [SW-1:0] nts_reg, nts_next;
    logic [SW-1:0] ae_reg, ae_next;
    logic [SW-1:0] fe_reg, fe_next;
    logic [SW-1:0] outst_reg, outst_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic          started_reg, started_next;
    logic          tp_reg, tp_next;
    logic          check_reg, check_next;
    logic          last_reg, last_next;

    // Latched item
    logic [WW-1:0] now_reg, now_next;
    logic [WW-1:0] pay_reg, pay_next;
    logic          has_data_reg, has_data_next;
    logic [SW-1:0] rx_seq_reg, rx_seq_next;
    logic [SW-1:0] rx_ack_reg, rx_ack_next;

    // Pending result contents
    logic          res_tx_reg, res_tx_next;
    logic          res_del_reg, res_del_next;
    logic [SW-1:0] res_seq_reg, res_seq_next;

    // Output register
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [gbn_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [gbn_pkg::M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                          m_tlast_reg, m_tlast_next;

    // Frame store and send-time table
    logic [WW-1:0]      fs_mem [gbn_pkg::SEQ_MOD];
    logic [WW-1:0]      fs_rd_reg;
    logic               fs_we;
    logic [WW-1:0]      st_mem_reg [gbn_pkg::SEQ_MOD];
    logic [gbn_pkg::SEQ_MOD-1:0] st_vld_reg;
    logic               st_we;

    // Shared age compare
    logic [WW-1:0] st_sel;
    logic [WW-1:0] age;
    logic          arm_hit;
    logic [SW-1:0] tx_ack;

    gbn_pkg::kind_t in_kind;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;
    assign in_kind   = gbn_pkg::kind_t'(s_tuser[1:0]);

    // Age of the oldest frame against max_wait
    assign st_sel  = st_vld_reg[ae_reg] ? st_mem_reg[ae_reg] : '0;
    assign age     = now_reg - st_sel;
    assign arm_hit = check_reg && started_reg && !tp_reg && (age > max_wait_reg);
    assign tx_ack  = fe_reg - SW'(1);

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_wait_reg <= gbn_pkg::MAX_WAIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            max_wait_reg <= cfg_data;
        end
    end

    // Frame store: write on send, registered read at next_to_send
    always_ff @(posedge aclk) begin
        if (fs_we) begin
            fs_mem[nts_reg] <= pay_reg;
        end
        fs_rd_reg <= fs_mem[nts_reg];
    end

    // Send-time table with valid bits standing for the zero reset
    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem_reg[nts_reg] <= now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg <= '0;
        end else if (st_we) begin
            st_vld_reg[nts_reg] <= 1'b1;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gbn_pkg::ST_IDLE;
            nts_reg      <= '0;
            ae_reg       <= '0;
            fe_reg       <= '0;
            outst_reg    <= '0;
            cnt_reg      <= '0;
            started_reg  <= 1'b0;
            tp_reg       <= 1'b0;
            check_reg    <= 1'b0;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            nts_reg      <= nts_next;
            ae_reg       <= ae_next;
            fe_reg       <= fe_next;
            outst_reg    <= outst_next;
            cnt_reg      <= cnt_next;
            started_reg  <= started_next;
            tp_reg       <= tp_next;
            check_reg    <= check_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        now_reg      <= now_next;
        pay_reg      <= pay_next;
        has_data_reg <= has_data_next;
        rx_seq_reg   <= rx_seq_next;
        rx_ack_reg   <= rx_ack_next;
        res_tx_reg   <= res_tx_next;
        res_del_reg  <= res_del_next;
        res_seq_reg  <= res_seq_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

    // Sequencer: next state and outputs
    always_comb begin
        state_next    = state_reg;
        nts_next      = nts_reg;
        ae_next       = ae_reg;
        fe_next       = fe_reg;
        outst_next    = outst_reg;
        cnt_next      = cnt_reg;
        started_next  = started_reg;
        tp_next       = tp_reg;
        check_next    = check_reg;
        last_next     = last_reg;
        now_next      = now_reg;
        pay_next      = pay_reg;
        has_data_next = has_data_reg;
        rx_seq_next   = rx_seq_reg;
        rx_ack_next   = rx_ack_reg;
        res_tx_next   = res_tx_reg;
        res_del_next  = res_del_reg;
        res_seq_next  = res_seq_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        s_tready      = 1'b0;
        fs_we         = 1'b0;
        st_we         = 1'b0;

        case (state_reg)
            gbn_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    // Latch the request and dispatch on its kind
                    now_next      = s_tdata[31:0];
                    has_data_next = s_tuser[2];
                    rx_seq_next   = s_tdata[66:64];
                    rx_ack_next   = s_tdata[69:67];
                    res_tx_next   = 1'b0;
                    res_del_next  = 1'b0;
                    res_seq_next  = '0;
                    check_next    = 1'b1;
                    pay_next      = s_tdata[101:70];
                    case (in_kind)
                        gbn_pkg::KIND_SEND: begin
                            pay_next   = s_tdata[63:32];
                            state_next = gbn_pkg::ST_SEND;
                        end
                        gbn_pkg::KIND_TIMEOUT: begin
                            tp_next  = 1'b0;
                            nts_next = ae_reg;
                            cnt_next = outst_reg;
                            if (outst_reg == '0) begin
                                state_next = gbn_pkg::ST_FIN;
                            end else begin
                                state_next = gbn_pkg::ST_TO_RD;
                            end
                        end
                        gbn_pkg::KIND_RX: begin
                            state_next = gbn_pkg::ST_ACK;
                        end
                        default: begin
                            // Unused kind: empty result, no age check
                            check_next = 1'b0;
                            state_next = gbn_pkg::ST_FIN;
                        end
                    endcase
                end
            end

            gbn_pkg::ST_SEND: begin
                // Store and emit a new frame if the window has room
                if (outst_reg < gbn_pkg::MAX_SEQ_V) begin
                    fs_we        = 1'b1;
                    st_we        = 1'b1;
                    outst_next   = outst_reg + SW'(1);
                    nts_next     = gbn_pkg::seq_inc(nts_reg);
                    started_next = 1'b1;
                    res_tx_next  = 1'b1;
                    res_seq_next = nts_reg;
                end
                state_next = gbn_pkg::ST_FIN;
            end

            gbn_pkg::ST_ACK: begin
                // Retire one acknowledged frame per cycle, then check delivery
                if ((outst_reg != '0) && gbn_pkg::in_window(ae_reg, rx_ack_reg, nts_reg)) begin
                    outst_next = outst_reg - SW'(1);
                    ae_next    = gbn_pkg::seq_inc(ae_reg);
                end else begin
                    if (has_data_reg && (rx_seq_reg == fe_reg)) begin
                        fe_next      = gbn_pkg::seq_inc(fe_reg);
                        res_del_next = 1'b1;
                    end
                    state_next = gbn_pkg::ST_FIN;
                end
            end

            gbn_pkg::ST_TO_RD: begin
                // Restamp the frame and read its payload
                st_we        = 1'b1;
                res_seq_next = nts_reg;
                nts_next     = gbn_pkg::seq_inc(nts_reg);
                cnt_next     = cnt_reg - SW'(1);
                state_next   = gbn_pkg::ST_TO_LD;
            end

            gbn_pkg::ST_TO_LD: begin
                // Load a resent frame; the final one carries the age check
                last_next     = (cnt_reg == '0);
                m_tvalid_next = 1'b1;
                m_tlast_next  = (cnt_reg == '0);
                m_tuser_next  = 2'b01;
                m_tdata_next  = {1'b0, ((cnt_reg == '0) && arm_hit), WW'(0),
                                 fs_rd_reg, tx_ack, res_seq_reg};
                if ((cnt_reg == '0) && arm_hit) begin
                    tp_next = 1'b1;
                end
                state_next = gbn_pkg::ST_OUT;
            end

            gbn_pkg::ST_FIN: begin
                // Load the final result of a single-result item
                last_next     = 1'b1;
                m_tvalid_next = 1'b1;
                m_tlast_next  = 1'b1;
                m_tuser_next  = {res_del_reg, res_tx_reg};
                m_tdata_next  = {1'b0, arm_hit,
                                 (res_del_reg ? pay_reg : WW'(0)),
                                 (res_tx_reg ? pay_reg : WW'(0)),
                                 (res_tx_reg ? tx_ack : SW'(0)),
                                 (res_tx_reg ? res_seq_reg : SW'(0))};
                if (arm_hit) begin
                    tp_next = 1'b1;
                end
                state_next = gbn_pkg::ST_OUT;
            end

            gbn_pkg::ST_OUT: begin
                // Hold the result until taken
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (last_reg) begin
                        state_next = gbn_pkg::ST_IDLE;
                    end else begin
                        state_next = gbn_pkg::ST_TO_RD;
                    end
                end
            end

            default: begin
                state_next = gbn_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/gbn_checker.sv
// ---------------------------------------------------------------------------
// gbn_checker: port-level checks for the go-back-N ARQ endpoint
// Watches the stream ports over time; attached to the endpoint core by bind.
// ---------------------------------------------------------------------------
module gbn_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gbn_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [gbn_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                           m_tlast
);

    // No new request is taken while a result is pending
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    // A stalled result holds its data and last flag
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    // A timeout is armed only on the final result of an item
    a_arm_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[gbn_pkg::M_ARM_BIT]) |-> m_tlast)
        else $error("arm_timeout on a non-final result");

    // Without a frame the frame fields are zero
    a_tx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[gbn_pkg::M_TXF_HI:0] == '0))
        else $error("frame fields set without tx_valid");

    // A result never carries both a frame and a delivery
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("frame and delivery in one result");

endmodule

bind go_back_n_arq_endpoint_core gbn_checker u_gbn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
